@@ hw/rtl/bfb_pkg.sv @@
// shared constants, codes and word types for the byte ring fifo burst unit
package bfb_pkg;

    localparam int DEPTH      = 256;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int MAX_POP    = 64;
    localparam int CNT_W      = 7;
    localparam int TOTAL_W    = 9;
    localparam logic [TOTAL_W-1:0] BURST_SAT = 9'd511;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_LVL_W = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    typedef struct packed {
        logic             is_pop;
        logic [7:0]       data;
        logic             burst_end;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic               stored;
        logic [TOTAL_W-1:0] total;
        logic               last;
        logic               now_empty;
    } res_t;

endpackage

@@ hw/rtl/bfb_ram.sv @@
// generic single write port ram with registered read
module bfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/bfb_front.sv @@
// front end: accepts input words, classifies them and queues commands
module bfb_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [7:0]                data_in,
    input  logic                      burst_end,
    input  logic [bfb_pkg::CNT_W-1:0] pop_count,
    output logic                      cmd_valid,
    output bfb_pkg::cmd_t             cmd_word,
    input  logic                      cmd_take
);

    bfb_pkg::cmd_t                   q_reg [bfb_pkg::CMDQ_DEPTH];
    logic [bfb_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bfb_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bfb_pkg::CMDQ_LVL_W-1:0]  level_reg, level_next;
    logic                            accept;
    bfb_pkg::cmd_t                   in_word;

    assign full      = (level_reg == bfb_pkg::CMDQ_LVL_W'(bfb_pkg::CMDQ_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (level_reg != '0);
    assign cmd_word  = q_reg[rd_ptr_reg];

    // pop requests beyond the burst limit are clipped here
    always_comb
    begin
        in_word.is_pop    = (cmd == bfb_pkg::CMD_POP);
        in_word.data      = data_in;
        in_word.burst_end = burst_end;
        if (pop_count > bfb_pkg::CNT_W'(bfb_pkg::MAX_POP))
        begin
            in_word.count = bfb_pkg::CNT_W'(bfb_pkg::MAX_POP);
        end
        else
        begin
            in_word.count = pop_count;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (accept && !cmd_take)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!accept && cmd_take)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

@@ hw/rtl/bfb_back.sv @@
// back end: owns the ring state, runs pushes and pop bursts, forms results
module bfb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  bfb_pkg::cmd_t                  cmd_word,
    output logic                           cmd_take,
    input  logic [bfb_pkg::OUTQ_LVL_W-1:0] out_level,
    output logic                           res_valid,
    output bfb_pkg::res_t                  res_word
);

    bfb_pkg::state_t                  state_reg, state_next;
    logic [bfb_pkg::ADDR_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [bfb_pkg::ADDR_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [bfb_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [bfb_pkg::TOTAL_W-1:0]      burst_reg, burst_next;
    logic [bfb_pkg::CNT_W-1:0]        want_reg, want_next;
    logic [bfb_pkg::CNT_W-1:0]        k_reg, k_next;
    logic                             r_valid_reg;
    bfb_pkg::res_t                    r_res_reg;

    logic [bfb_pkg::OUTQ_LVL_W:0]     credit_sum;
    logic                             can_issue;
    logic                             issue;
    bfb_pkg::res_t                    iss_res;
    logic                             ram_we;
    logic                             ram_re;
    logic [7:0]                       ram_rdata;
    logic [bfb_pkg::TOTAL_W-1:0]      burst_inc;
    logic [bfb_pkg::CNT_W-1:0]        want_calc;
    logic [bfb_pkg::CNT_W-1:0]        k_inc;

    // one result in flight between issue and the result queue
    assign credit_sum = {1'b0, out_level} + {{bfb_pkg::OUTQ_LVL_W{1'b0}}, r_valid_reg};
    assign can_issue  = (credit_sum < (bfb_pkg::OUTQ_LVL_W + 1)'(bfb_pkg::OUTQ_DEPTH));

    assign burst_inc = (burst_reg != bfb_pkg::BURST_SAT) ? burst_reg + 1'b1 : burst_reg;
    assign k_inc     = k_reg + 1'b1;

    always_comb
    begin
        if ({{(bfb_pkg::FILL_W - bfb_pkg::CNT_W){1'b0}}, cmd_word.count} < fill_reg)
        begin
            want_calc = cmd_word.count;
        end
        else
        begin
            want_calc = fill_reg[bfb_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        fill_next   = fill_reg;
        burst_next  = burst_reg;
        want_next   = want_reg;
        k_next      = k_reg;
        cmd_take    = 1'b0;
        issue       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        iss_res     = '0;
        case (state_reg)
            bfb_pkg::ST_IDLE:
            begin
                if (cmd_valid && can_issue)
                begin
                    cmd_take = 1'b1;
                    if (!cmd_word.is_pop)
                    begin
                        issue        = 1'b1;
                        iss_res.kind = bfb_pkg::KIND_ACK;
                        iss_res.last = 1'b1;
                        iss_res.total = burst_reg;
                        if (fill_reg < bfb_pkg::FILL_W'(bfb_pkg::DEPTH))
                        begin
                            ram_we         = 1'b1;
                            wr_idx_next    = (wr_idx_reg == bfb_pkg::ADDR_W'(bfb_pkg::DEPTH - 1))
                                           ? '0 : wr_idx_reg + 1'b1;
                            fill_next      = fill_reg + 1'b1;
                            burst_next     = burst_inc;
                            iss_res.stored = 1'b1;
                            iss_res.total  = burst_inc;
                        end
                        iss_res.now_empty = (fill_next == '0);
                        if (cmd_word.burst_end)
                        begin
                            burst_next = '0;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        issue             = 1'b1;
                        iss_res.kind      = bfb_pkg::KIND_EMPTY;
                        iss_res.last      = 1'b1;
                        iss_res.now_empty = 1'b1;
                    end
                    else if (want_calc != '0)
                    begin
                        want_next  = want_calc;
                        k_next     = '0;
                        state_next = bfb_pkg::ST_POP;
                    end
                end
            end
            bfb_pkg::ST_POP:
            begin
                if (can_issue)
                begin
                    issue             = 1'b1;
                    ram_re            = 1'b1;
                    rd_idx_next       = (rd_idx_reg == bfb_pkg::ADDR_W'(bfb_pkg::DEPTH - 1))
                                      ? '0 : rd_idx_reg + 1'b1;
                    fill_next         = fill_reg - 1'b1;
                    k_next            = k_inc;
                    iss_res.kind      = bfb_pkg::KIND_BYTE;
                    iss_res.total     = bfb_pkg::TOTAL_W'(k_inc);
                    iss_res.last      = (k_inc == want_reg);
                    iss_res.now_empty = (fill_next == '0);
                    if (k_inc == want_reg)
                    begin
                        state_next = bfb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bfb_pkg::ST_IDLE;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            burst_reg   <= '0;
            want_reg    <= '0;
            k_reg       <= '0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            fill_reg    <= fill_next;
            burst_reg   <= burst_next;
            want_reg    <= want_next;
            k_reg       <= k_next;
            r_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        r_res_reg <= iss_res;
    end

    bfb_ram #(
        .WIDTH (8),
        .DEPTH (bfb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (cmd_word.data),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // byte from the store lands in the cycle after the read is issued
    always_comb
    begin
        res_word = r_res_reg;
        if (r_res_reg.kind == bfb_pkg::KIND_BYTE)
        begin
            res_word.data = ram_rdata;
        end
    end

    assign res_valid = r_valid_reg;

endmodule

@@ hw/rtl/bfb_out_queue.sv @@
// small result queue that decouples the back end from the consumer
module bfb_out_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  bfb_pkg::res_t                  wr_word,
    output logic [bfb_pkg::OUTQ_LVL_W-1:0] level,
    output logic                           empty,
    input  logic                           pop,
    output bfb_pkg::res_t                  rd_word
);

    bfb_pkg::res_t                   q_reg [bfb_pkg::OUTQ_DEPTH];
    logic [bfb_pkg::OUTQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bfb_pkg::OUTQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bfb_pkg::OUTQ_LVL_W-1:0]  level_reg, level_next;
    logic                            take;

    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign take    = pop && !empty;
    assign rd_word = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !take)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!wr_en && take)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

@@ hw/rtl/byte_ring_fifo_burst_unit.sv @@
// top level of the byte ring fifo burst unit
// A 256-byte ring buffer driven by push and pop-request words. A push word
// is taken by the back end and yields one acknowledge. A pop request for
// n bytes yields n byte words, with n clipped to 64 and to the bytes held.
// A pop on an empty ring gives one empty word, and a zero count on a
// non-empty ring gives nothing. The sequencer serves one result per cycle
// while the result queue has room. A four-deep command queue in front and
// a four-deep result queue behind let input and output stall independently.
// With both queues idle, an acknowledge or empty word reaches the result
// ports through the command queue, the result register and the result
// queue; the first byte of a pop also passes through the pop state.
module byte_ring_fifo_burst_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [7:0]                data_in,
    input  logic                      burst_end,
    input  logic [bfb_pkg::CNT_W-1:0] pop_count,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                kind,
    output logic [7:0]                data_out,
    output logic                      stored,
    output logic [8:0]                burst_total,
    output logic                      last,
    output logic                      now_empty
);

    logic                           cmd_valid;
    bfb_pkg::cmd_t                  cmd_word;
    logic                           cmd_take;
    logic                           res_valid;
    bfb_pkg::res_t                  res_word;
    logic [bfb_pkg::OUTQ_LVL_W-1:0] out_level;
    bfb_pkg::res_t                  rd_word;

    bfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .data_in   (data_in),
        .burst_end (burst_end),
        .pop_count (pop_count),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .cmd_take  (cmd_take)
    );

    bfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .cmd_take  (cmd_take),
        .out_level (out_level),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    bfb_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_word (res_word),
        .level   (out_level),
        .empty   (empty),
        .pop     (pop),
        .rd_word (rd_word)
    );

    assign kind        = rd_word.kind;
    assign data_out    = rd_word.data;
    assign stored      = rd_word.stored;
    assign burst_total = rd_word.total;
    assign last        = rd_word.last;
    assign now_empty   = rd_word.now_empty;

endmodule

@@ tb/byte_ring_fifo_burst_unit_tb.sv @@
// testbench for the byte ring fifo burst unit: directed, full-ring and random word traffic
module byte_ring_fifo_burst_unit_tb;

    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 24;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic                        cmd;
    logic [7:0]                  data_in;
    logic                        burst_end;
    logic [bfb_pkg::CNT_W-1:0]   pop_count;
    logic                        empty;
    logic                        pop;
    logic [1:0]                  kind;
    logic [7:0]                  data_out;
    logic                        stored;
    logic [bfb_pkg::TOTAL_W-1:0] burst_total;
    logic                        last;
    logic                        now_empty;

    // predicted ring contents and counters
    logic [7:0]                  ring_mem [bfb_pkg::DEPTH];
    logic [bfb_pkg::ADDR_W-1:0]  wr_ptr;
    logic [bfb_pkg::ADDR_W-1:0]  rd_ptr;
    int                          ring_fill;
    logic [bfb_pkg::TOTAL_W-1:0] burst_count;

    bfb_pkg::res_t expected_results [$];
    int            error_count;
    int            idle_cycles;
    int            pop_stall_left;
    bit            quiet;

    byte_ring_fifo_burst_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .data_in     (data_in),
        .burst_end   (burst_end),
        .pop_count   (pop_count),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .data_out    (data_out),
        .stored      (stored),
        .burst_total (burst_total),
        .last        (last),
        .now_empty   (now_empty)
    );

    always #1 clk = ~clk;

    function automatic logic [bfb_pkg::ADDR_W-1:0] next_ptr(
        input logic [bfb_pkg::ADDR_W-1:0] p);
        return (p == bfb_pkg::ADDR_W'(bfb_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void predict_word(input logic c, input logic [7:0] d, input logic be,
                                         input logic [bfb_pkg::CNT_W-1:0] n);
        bfb_pkg::res_t r;
        int            want;
        int            k;
        r = '0;
        if (c == bfb_pkg::CMD_PUSH)
        begin
            if (ring_fill < bfb_pkg::DEPTH)
            begin
                ring_mem[wr_ptr] = d;
                wr_ptr = next_ptr(wr_ptr);
                ring_fill++;
                r.stored = 1'b1;
                if (burst_count < bfb_pkg::BURST_SAT)
                    burst_count++;
            end
            r.kind = bfb_pkg::KIND_ACK;
            r.total = burst_count;
            r.last = 1'b1;
            r.now_empty = (ring_fill == 0);
            expected_results.push_back(r);
            // burst closes even when the byte was dropped
            if (be)
                burst_count = '0;
        end
        else if (ring_fill == 0)
        begin
            r.kind = bfb_pkg::KIND_EMPTY;
            r.last = 1'b1;
            r.now_empty = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            want = (n > bfb_pkg::MAX_POP) ? bfb_pkg::MAX_POP : int'(n);
            if (want > ring_fill)
                want = ring_fill;
            for (k = 0; k < want; k++)
            begin
                r.kind = bfb_pkg::KIND_BYTE;
                r.data = ring_mem[rd_ptr];
                rd_ptr = next_ptr(rd_ptr);
                ring_fill--;
                r.stored = 1'b0;
                r.total = bfb_pkg::TOTAL_W'(k + 1);
                r.last = (k + 1 == want);
                r.now_empty = (ring_fill == 0);
                expected_results.push_back(r);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // called at a falling edge; leaves push high after acceptance so the next word follows
    task automatic send_word(input logic c, input logic [7:0] d, input logic be,
                             input logic [bfb_pkg::CNT_W-1:0] n);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        push = 1'b1;
        cmd = c;
        data_in = d;
        burst_end = be;
        pop_count = n;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_word(c, d, be, n);
        @(negedge clk);
    endtask

    task automatic send_push(input logic [7:0] d, input logic be);
        send_word(bfb_pkg::CMD_PUSH, d, be, bfb_pkg::CNT_W'($urandom_range(0, 127)));
    endtask

    task automatic send_pop(input logic [bfb_pkg::CNT_W-1:0] n);
        send_word(bfb_pkg::CMD_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), n);
    endtask

    task automatic wait_for_drain();
        push = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_pops();
        send_pop(7'd1);
        send_pop(7'd0);
        send_pop(7'd127);
    endtask

    task automatic test_directed_words();
        send_push(8'h00, 1'b0);
        send_push(8'hFF, 1'b0);
        send_push(8'hA5, 1'b1);
        send_push(8'h5A, 1'b0);
        // zero count on a non-empty ring gives nothing back
        send_pop(7'd0);
        send_pop(7'd2);
        // count above the maximum, then limited by what is held
        send_pop(7'd127);
        send_pop(7'd1);
        send_push(8'h81, 1'b1);
        send_push(8'h7E, 1'b1);
        send_pop(7'd64);
        send_pop(7'd65);
        wait_for_drain();
    endtask

    task automatic test_full_ring();
        int i;
        // ring starts empty with a closed burst, so the burst count climbs past 255
        for (i = 0; i < bfb_pkg::DEPTH; i++)
            send_push(8'($urandom_range(0, 255)), 1'b0);
        // ring is full: dropped and leaves the burst count alone
        send_push(8'($urandom_range(0, 255)), 1'b0);
        // dropped byte that closes the burst
        send_push(8'($urandom_range(0, 255)), 1'b1);
        send_pop(7'd64);
        send_pop(7'd64);
    endtask

    task automatic test_random_traffic();
        int i;
        int sel;
        logic [bfb_pkg::CNT_W-1:0] n;
        for (i = 0; i < 16; i++)
        begin
            if (i >= 8)
                quiet = 1'b1;
            if ($urandom_range(0, 99) < 50)
            begin
                send_push(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    n = bfb_pkg::CNT_W'($urandom_range(1, 8));
                else if (sel < 85)
                    n = bfb_pkg::CNT_W'($urandom_range(9, 64));
                else if (sel < 95)
                    n = bfb_pkg::CNT_W'($urandom_range(65, 127));
                else
                    n = '0;
                send_pop(n);
            end
        end
        push = 1'b0;
    endtask

    // result side: random stall bursts, none once traffic goes quiet
    always @(negedge clk)
    begin
        if (quiet)
        begin
            pop <= 1'b1;
        end
        else if (pop_stall_left > 0)
        begin
            pop <= 1'b0;
            pop_stall_left <= pop_stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            pop <= 1'b0;
            pop_stall_left <= $urandom_range(0, 11);
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        bfb_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected word, kind", kind, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (data_out !== want.data)
                    report_mismatch("data_out", data_out, want.data);
                if (stored !== want.stored)
                    report_mismatch("stored", stored, want.stored);
                if (burst_total !== want.total)
                    report_mismatch("burst_total", burst_total, want.total);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
                if (now_empty !== want.now_empty)
                    report_mismatch("now_empty", now_empty, want.now_empty);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("byte_ring_fifo_burst_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        cmd = bfb_pkg::CMD_PUSH;
        data_in = '0;
        burst_end = 1'b0;
        pop_count = '0;
        wr_ptr = '0;
        rd_ptr = '0;
        ring_fill = 0;
        burst_count = '0;
        error_count = 0;
        idle_cycles = 0;
        pop_stall_left = 0;
        quiet = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_pops();
        test_directed_words();
        test_full_ring();
        test_random_traffic();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("byte_ring_fifo_burst_unit: match");
        else
            $display("byte_ring_fifo_burst_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bfb_pkg.sv
hw/rtl/bfb_ram.sv
hw/rtl/bfb_front.sv
hw/rtl/bfb_back.sv
hw/rtl/bfb_out_queue.sv
hw/rtl/byte_ring_fifo_burst_unit.sv
tb/byte_ring_fifo_burst_unit_tb.sv
